// ----- rtl/evaf_pkg.sv -----
`timescale 1ns / 1ps

package evaf_pkg;

    localparam int unsigned ONSET_FRAMES = 3;

    localparam logic [23:0] NF_RESET   = 24'd42666;
    localparam logic [10:0] ALPHA_NUM  = 11'd1311;
    localparam logic [15:0] ALPHA_KEEP = 16'd64225;

    localparam logic [15:0] RMS_THRESHOLD_RESET    = 16'd500;
    localparam logic [15:0] SILENCE_FRAMES_RESET   = 16'd25;
    localparam logic [9:0]  FRAME_MS_RESET         = 10'd20;
    localparam logic [31:0] MAX_UTTERANCE_MS_RESET = 32'd10000;

    localparam int unsigned CFG_INDEX_W = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_RMS_THRESHOLD    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SILENCE_FRAMES   = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_MS         = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_UTTERANCE_MS = 8'd3;

    localparam logic FUNC_FEED    = 1'b0;
    localparam logic FUNC_RESTART = 1'b1;

    typedef struct packed {
        logic        func;
        logic [15:0] rms;
    } in_item_t;

    typedef struct packed {
        logic        utterance_done;
        logic        speech_heard;
        logic [31:0] elapsed_ms;
        logic        timed_out;
    } out_item_t;

endpackage

// ----- rtl/energy_vad_adaptive_floor_unit.sv -----
`timescale 1ns / 1ps

// pipeline: the state update stage registers the accepted input, then the
// elapsed-time multiply stage registers the result
// throughput: one item per cycle unless m_ready stalls the output
// reset: aresetn synchronous active low; registers return to defaults,
// counters and heard flag clear, noise floor returns to its fixed start value
module energy_vad_adaptive_floor_unit #(
    parameter int unsigned ONSET_FRAMES = evaf_pkg::ONSET_FRAMES
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  evaf_pkg::in_item_t                 s_data,

    output logic                               m_valid,
    input  logic                               m_ready,
    output evaf_pkg::out_item_t                m_data,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [evaf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [31:0]                        cfg_data
);

    logic [15:0] rms_threshold_reg;
    logic [15:0] silence_frames_reg;
    logic [9:0]  frame_ms_reg;
    logic [31:0] max_utterance_ms_reg;

    logic [31:0] frame_count_reg, frame_count_next;
    logic [15:0] silence_run_reg, silence_run_next;
    logic [15:0] speech_run_reg, speech_run_next;
    logic        heard_reg, heard_next;
    logic [23:0] noise_floor_reg, noise_floor_next;

    logic        p1_valid_reg;
    logic [31:0] p1_count_reg;
    logic        p1_heard_reg;
    logic        p1_done_reg;

    logic                m_valid_reg;
    evaf_pkg::out_item_t out_reg, out_next;

    logic        s_fire, adv2;
    logic [26:0] scaled;
    logic [15:0] dyn_thr, thr;
    logic        loud;
    logic [39:0] keep_prod;
    logic [34:0] gain_prod;
    logic [39:0] acc;
    logic [41:0] elapsed_prod;

    assign cfg_ready = 1'b1;

    assign adv2    = !m_valid_reg || m_ready;
    assign s_ready = !p1_valid_reg || adv2;
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rms_threshold_reg    <= evaf_pkg::RMS_THRESHOLD_RESET;
            silence_frames_reg   <= evaf_pkg::SILENCE_FRAMES_RESET;
            frame_ms_reg         <= evaf_pkg::FRAME_MS_RESET;
            max_utterance_ms_reg <= evaf_pkg::MAX_UTTERANCE_MS_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                evaf_pkg::REG_RMS_THRESHOLD:    rms_threshold_reg    <= cfg_data[15:0];
                evaf_pkg::REG_SILENCE_FRAMES:   silence_frames_reg   <= cfg_data[15:0];
                evaf_pkg::REG_FRAME_MS:         frame_ms_reg         <= cfg_data[9:0];
                evaf_pkg::REG_MAX_UTTERANCE_MS: max_utterance_ms_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // threshold: max of configured floor and 2.5x noise floor, saturated
    always_comb begin
        scaled  = 27'(noise_floor_reg) * 27'd5;
        dyn_thr = (|scaled[26:25]) ? 16'hFFFF : scaled[24:9];
        thr     = (dyn_thr > rms_threshold_reg) ? dyn_thr : rms_threshold_reg;
        loud    = s_data.rms > thr;

        keep_prod = 40'(noise_floor_reg) * 40'(evaf_pkg::ALPHA_KEEP);
        gain_prod = 35'({s_data.rms, 8'd0}) * 35'(evaf_pkg::ALPHA_NUM);
        acc       = keep_prod + 40'(gain_prod);
    end

    always_comb begin
        frame_count_next = frame_count_reg;
        silence_run_next = silence_run_reg;
        speech_run_next  = speech_run_reg;
        heard_next       = heard_reg;
        noise_floor_next = noise_floor_reg;
        if (s_data.func == evaf_pkg::FUNC_RESTART) begin
            frame_count_next = '0;
            silence_run_next = '0;
            speech_run_next  = '0;
            heard_next       = 1'b0;
        end else begin
            if (!(&frame_count_reg)) begin
                frame_count_next = frame_count_reg + 32'd1;
            end
            if (loud) begin
                if (!(&speech_run_reg)) begin
                    speech_run_next = speech_run_reg + 16'd1;
                end
                silence_run_next = '0;
                if (speech_run_next >= 16'(ONSET_FRAMES)) begin
                    heard_next = 1'b1;
                end
            end else begin
                speech_run_next = '0;
                if (!(&silence_run_reg)) begin
                    silence_run_next = silence_run_reg + 16'd1;
                end
                noise_floor_next = acc[39:16];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_count_reg <= '0;
            silence_run_reg <= '0;
            speech_run_reg  <= '0;
            heard_reg       <= 1'b0;
            noise_floor_reg <= evaf_pkg::NF_RESET;
            p1_valid_reg    <= 1'b0;
        end else begin
            if (s_fire) begin
                frame_count_reg <= frame_count_next;
                silence_run_reg <= silence_run_next;
                speech_run_reg  <= speech_run_next;
                heard_reg       <= heard_next;
                noise_floor_reg <= noise_floor_next;
                p1_valid_reg    <= 1'b1;
            end else if (adv2) begin
                p1_valid_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            p1_count_reg <= frame_count_next;
            p1_heard_reg <= heard_next;
            p1_done_reg  <= heard_next && (silence_run_next >= silence_frames_reg);
        end
    end

    // elapsed time multiply and timeout compare
    always_comb begin
        elapsed_prod           = 42'(p1_count_reg) * 42'(frame_ms_reg);
        out_next.elapsed_ms    = (|elapsed_prod[41:32]) ? 32'hFFFF_FFFF
                                                        : elapsed_prod[31:0];
        out_next.timed_out     = out_next.elapsed_ms >= max_utterance_ms_reg;
        out_next.speech_heard  = p1_heard_reg;
        out_next.utterance_done = p1_done_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv2) begin
            m_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2 && p1_valid_reg) begin
            out_reg <= out_next;
        end
    end

endmodule
